// ===== design/chte_pkg.sv =====
// Package for the chained hash table engine: field widths, status and action codes,
// and the packed beat types. No dependencies.
package chte_pkg;

  localparam int MaxBucketBits = 10;
  localparam int MinBucketBits = 3;
  localparam int ScanSlots     = 7;
  localparam int IdxW          = MaxBucketBits + 1;
  localparam int Depth         = 2 << MaxBucketBits;
  localparam int KeyW          = 32;
  localparam int ValW          = 31;
  localparam int BbW           = 4;
  localparam int OccW          = IdxW + 1;
  localparam int ScanW         = $clog2(ScanSlots + 1);

  localparam logic [1:0] ActLookup = 2'd0;
  localparam logic [1:0] ActInsert = 2'd1;
  localparam logic [1:0] ActRemove = 2'd2;
  localparam logic [1:0] ActUnused = 2'd3;

  localparam logic [2:0] StOk     = 3'd0;
  localparam logic [2:0] StMiss   = 3'd1;
  localparam logic [2:0] StNew    = 3'd2;
  localparam logic [2:0] StFull   = 3'd3;
  localparam logic [2:0] StBadKey = 3'd4;

  typedef struct packed {
    logic [1:0]      action;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value_index;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [ValW-1:0] value_out;
  } out_beat_t;

  // One entry of the table as stored: key, value and link side by side.
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [ValW-1:0] val;
    logic [IdxW-1:0] link;
  } entry_t;

  // Write request toward the entry memory.
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] addr;
    entry_t          data;
  } mem_wr_t;

endpackage

// ===== design/chained_hash_table_engine.sv =====
// Chained hash table engine top level: control sequencer around the entry memory.
// Depends on chte_pkg and chte_mem.
// busy covers the head read and check (a bad key skips the check), a read and check per
// further chain node, and on an insert that misses one per scanned slot and the tail link;
// the result strobe follows busy, and the next item may be taken then.
// Reset clears every key while busy; the receiver cannot stall.
module chained_hash_table_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  chte_pkg::in_beat_t            in_data,
  output logic                          out_valid,
  output chte_pkg::out_beat_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [chte_pkg::BbW-1:0]      cfg_bucket_bits
);

  localparam int IdxW = chte_pkg::IdxW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HEAD_RD, S_HEAD_CHK, S_WALK_RD, S_WALK_CHK,
    S_SCAN_RD, S_SCAN_CHK, S_REM_RD, S_REM_CHK, S_RNODE_RD, S_RNODE_CHK, S_DONE
  } state_t;

  state_t                   state_r;
  chte_pkg::in_beat_t       req_r;
  logic [chte_pkg::BbW-1:0] bb_r;
  logic [chte_pkg::OccW-1:0] occ_r;
  logic [IdxW-1:0]          cur_r, prev_r, head_r, slot_r;
  logic [IdxW:0]            steps_r;
  logic [chte_pkg::ScanW-1:0] scan_r;
  chte_pkg::entry_t         cur_ent_r, prev_ent_r;
  chte_pkg::out_beat_t      res_r;
  logic                     out_valid_r;

  chte_pkg::mem_wr_t        wr;
  logic [IdxW-1:0]          rd_addr;
  chte_pkg::entry_t         rd_data;

  chte_mem u_mem (.clk(clk), .wr(wr), .rd_addr(rd_addr), .rd_data(rd_data));

  // Table size minus one, and the head index of the current key.
  logic [IdxW-1:0] size_m1, head_idx, link_m, scan_start, scan_slot;
  logic [IdxW:0]   size_w;
  logic [IdxW:0]   bucket_m1;
  logic [chte_pkg::BbW-1:0] cfg_clamped;
  logic            occ_zero;

  always_comb begin
    size_w    = (IdxW+1)'(2) << bb_r;
    size_m1   = IdxW'(size_w - 1'b1);
    bucket_m1 = (size_w >> 1) - 1'b1;
    head_idx  = IdxW'((req_r.key[IdxW-1:0] & bucket_m1[IdxW-1:0]) << 1);
    link_m    = rd_data.link & size_m1;
    scan_start = (size_w - {1'b0, head_r} - 1'b1 < (IdxW+1)'(2 * chte_pkg::ScanSlots))
                 ? IdxW'(1) : head_r + 1'b1;
    scan_slot = (scan_start + {scan_r, 1'b0}) & size_m1;
    occ_zero  = (occ_r == '0);
    if (cfg_bucket_bits < chte_pkg::BbW'(chte_pkg::MinBucketBits)) begin
      cfg_clamped = chte_pkg::BbW'(chte_pkg::MinBucketBits);
    end else if (cfg_bucket_bits > chte_pkg::BbW'(chte_pkg::MaxBucketBits)) begin
      cfg_clamped = chte_pkg::BbW'(chte_pkg::MaxBucketBits);
    end else begin
      cfg_clamped = cfg_bucket_bits;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  // Read address is chosen from the state being entered.
  state_t state_nxt;
  always_comb begin
    rd_addr = cur_r;
    case (state_nxt)
      S_HEAD_CHK: rd_addr = head_idx;
      S_SCAN_CHK: rd_addr = scan_slot;
      default:    rd_addr = cur_r;
    endcase
  end

  logic [IdxW-1:0]      cur_nxt, prev_nxt, slot_nxt;
  logic [IdxW:0]        steps_nxt;
  logic [chte_pkg::ScanW-1:0] scan_nxt;
  chte_pkg::entry_t     cur_ent_nxt, prev_ent_nxt;
  chte_pkg::out_beat_t  res_nxt;
  logic                 out_valid_nxt;
  logic [chte_pkg::OccW-1:0] occ_nxt;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    slot_nxt      = slot_r;
    steps_nxt     = steps_r;
    scan_nxt      = scan_r;
    cur_ent_nxt   = cur_ent_r;
    prev_ent_nxt  = prev_ent_r;
    res_nxt       = res_r;
    out_valid_nxt = 1'b0;
    occ_nxt       = occ_r;
    wr            = '0;
    case (state_r)
      S_CLEAR: begin
        wr.we   = 1'b1;
        wr.addr = cur_r;
        cur_nxt = cur_r + 1'b1;
        if (cur_r == IdxW'(chte_pkg::Depth - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_HEAD_RD;
        end
      end
      S_HEAD_RD: begin
        res_nxt = '{status: chte_pkg::StMiss, value_out: '0};
        cur_nxt = head_idx;
        steps_nxt = '0;
        if (req_r.key == '0) begin
          res_nxt.status = chte_pkg::StBadKey;
          state_nxt = S_DONE;
        end else if (req_r.action == chte_pkg::ActRemove) begin
          state_nxt = S_REM_RD;
        end else if (req_r.action == chte_pkg::ActLookup ||
                     req_r.action == chte_pkg::ActInsert) begin
          state_nxt = S_HEAD_CHK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_HEAD_CHK: begin
        // Memory output now holds the head entry.
        if (rd_data.key == '0) begin
          if (req_r.action == chte_pkg::ActInsert) begin
            wr = '{we: 1'b1, addr: cur_r,
                   data: '{key: req_r.key, val: req_r.value_index, link: '0}};
            occ_nxt = occ_r + 1'b1;
            res_nxt.status = chte_pkg::StNew;
          end
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_WALK_CHK;
        end
      end
      S_WALK_RD: begin
        state_nxt = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        cur_ent_nxt = rd_data;
        steps_nxt   = steps_r + 1'b1;
        if (rd_data.key == req_r.key) begin
          res_nxt.status = chte_pkg::StOk;
          if (req_r.action == chte_pkg::ActLookup) begin
            res_nxt.value_out = rd_data.val;
          end else begin
            wr = '{we: 1'b1, addr: cur_r,
                   data: '{key: rd_data.key, val: req_r.value_index, link: rd_data.link}};
          end
          state_nxt = S_DONE;
        end else if (link_m == '0 || steps_r + 1'b1 >= size_w) begin
          if (req_r.action == chte_pkg::ActInsert) begin
            res_nxt.status = chte_pkg::StFull;
            scan_nxt = '0;
            state_nxt = S_SCAN_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          cur_nxt = link_m;
          state_nxt = S_WALK_RD;
        end
      end
      S_SCAN_RD: begin
        slot_nxt  = scan_slot;
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (rd_data.key == '0) begin
          // Free slot: fill it now, link the tail next cycle in S_RNODE_CHK.
          wr = '{we: 1'b1, addr: slot_r,
                 data: '{key: req_r.key, val: req_r.value_index, link: '0}};
          occ_nxt = occ_r + 1'b1;
          res_nxt.status = chte_pkg::StNew;
          prev_ent_nxt = cur_ent_r;
          prev_ent_nxt.link = slot_r;
          prev_nxt = cur_r;
          state_nxt = S_RNODE_CHK;
        end else if (scan_r == chte_pkg::ScanW'(chte_pkg::ScanSlots - 1)) begin
          state_nxt = S_DONE;
        end else begin
          scan_nxt  = scan_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_REM_RD: begin
        state_nxt = S_REM_CHK;
      end
      S_REM_CHK: begin
        prev_ent_nxt = rd_data;
        prev_nxt     = cur_r;
        if (rd_data.key == '0) begin
          state_nxt = S_DONE;
        end else if (link_m == '0 && rd_data.key == req_r.key) begin
          wr = '{we: 1'b1, addr: cur_r, data: '{key: '0, val: rd_data.val, link: rd_data.link}};
          occ_nxt = occ_r - 1'b1;
          res_nxt = '{status: chte_pkg::StOk, value_out: rd_data.val};
          state_nxt = S_DONE;
        end else if (link_m == '0) begin
          state_nxt = S_DONE;
        end else begin
          cur_nxt   = link_m;
          state_nxt = S_RNODE_RD;
        end
      end
      S_RNODE_RD: begin
        state_nxt = S_RNODE_CHK;
      end
      S_RNODE_CHK: begin
        if (res_r.status == chte_pkg::StNew) begin
          // Tail link write after an insert.
          wr = '{we: 1'b1, addr: prev_r, data: prev_ent_r};
          state_nxt = S_DONE;
        end else if (prev_ent_r.key == req_r.key && prev_r == head_r) begin
          // Head matched: successor moves into the head and is freed.
          wr = '{we: 1'b1, addr: head_r, data: rd_data};
          slot_nxt = cur_r;
          occ_nxt = occ_r - 1'b1;
          res_nxt = '{status: chte_pkg::StOk, value_out: prev_ent_r.val};
          cur_ent_nxt = rd_data;
          state_nxt = S_DONE;
        end else if (rd_data.key == req_r.key) begin
          wr = '{we: 1'b1, addr: prev_r,
                 data: '{key: prev_ent_r.key, val: prev_ent_r.val, link: rd_data.link}};
          slot_nxt = cur_r;
          occ_nxt = occ_r - 1'b1;
          res_nxt = '{status: chte_pkg::StOk, value_out: rd_data.val};
          state_nxt = S_DONE;
        end else if (link_m == '0 || steps_r + 1'b1 >= size_w) begin
          state_nxt = S_DONE;
        end else begin
          steps_nxt    = steps_r + 1'b1;
          prev_ent_nxt = rd_data;
          prev_nxt     = cur_r;
          cur_nxt      = link_m;
          state_nxt    = S_RNODE_RD;
        end
      end
      S_DONE: begin
        // A freed node from a remove gets its key cleared here.
        if (req_r.action == chte_pkg::ActRemove && res_r.status == chte_pkg::StOk &&
            slot_r != prev_r && req_r.key != '0 && head_r != slot_r) begin
          wr = '{we: 1'b1, addr: slot_r, data: '{key: '0, val: cur_ent_r.val,
                 link: cur_ent_r.link}};
        end
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cur_r       <= '0;
      bb_r        <= chte_pkg::BbW'(chte_pkg::MaxBucketBits);
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && occ_zero) begin
        bb_r <= cfg_clamped;
      end
    end
    if (state_r == S_IDLE && start) begin
      req_r <= in_data;
    end
    if (state_r == S_HEAD_RD) begin
      head_r <= head_idx;
      slot_r <= head_idx;
    end else begin
      slot_r <= slot_nxt;
    end
    prev_r     <= prev_nxt;
    steps_r    <= steps_nxt;
    scan_r     <= scan_nxt;
    cur_ent_r  <= cur_ent_nxt;
    prev_ent_r <= prev_ent_nxt;
    res_r      <= res_nxt;
  end

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == S_DONE)
    else $error("result strobe without completion");
  a_bb_range: assert property (@(posedge clk) disable iff (!rst_n)
    bb_r >= chte_pkg::BbW'(chte_pkg::MinBucketBits) &&
    bb_r <= chte_pkg::BbW'(chte_pkg::MaxBucketBits))
    else $error("bucket_bits out of range");
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= chte_pkg::OccW'(chte_pkg::Depth))
    else $error("occupancy overflow");
`endif

endmodule

// ===== design/chte_mem.sv =====
// Entry memory of the hash table: one write port, one read port, registered read data.
// Depends on chte_pkg.
module chte_mem (
  input  logic                       clk,
  input  chte_pkg::mem_wr_t          wr,
  input  logic [chte_pkg::IdxW-1:0]  rd_addr,
  output chte_pkg::entry_t           rd_data
);

  chte_pkg::entry_t mem [chte_pkg::Depth];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
